FILE: src/motor_speed_pid_duty_defines.svh
// Assertion macros shared by the speed controller RTL.
// Depends on nothing; taken in by files that carry concurrent assertions.
`ifndef MOTOR_SPEED_PID_DUTY_DEFINES_SVH
`define MOTOR_SPEED_PID_DUTY_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define MSPD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MSPD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mspd_pkg.sv
// Shared types and constants for the PID speed controller.
// No dependencies; used by every module under src.
`default_nettype none

package mspd_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_GAIN_P = 2'd0;
    localparam logic [1:0] REG_GAIN_I = 2'd1;
    localparam logic [1:0] REG_GAIN_D = 2'd2;

    localparam int GAIN_W   = 16;
    localparam int INDEX_W  = 2;
    localparam int SPEED_W  = 15;
    localparam int ERR_W    = 16;
    localparam int DUTY_W   = 24;
    localparam int MAG_W    = 7;

    // Q16 percent
    localparam int DUTY_ONE = 65536;
    localparam int DUTY_MAX = 6553600;
    // Q8 step limit: anything past this already drives the duty into the clamp
    localparam int STEP_LIMIT = 131072;
    localparam int MAG_MAX    = 100;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    typedef struct packed {
        logic signed [DUTY_W-1:0] duty_fixed;
        logic                     drive_b;
        logic                     drive_a;
        logic [MAG_W-1:0]         duty_magnitude;
    } result_t;

endpackage

`default_nettype wire

FILE: src/motor_speed_pid_duty.sv
// Top level of the PID speed controller with duty output.
// Depends on mspd_pkg, mspd_gains, mspd_law and motor_speed_pid_duty_defines.svh.
`default_nettype none
`include "motor_speed_pid_duty_defines.svh"

// Each input word is one control tick (desired and measured speed). The word
// lands in an input register; once the result register is free or draining,
// the control law runs through the error sum, the three gain multipliers, the
// duty update and the clamps, updates the controller state and writes the
// result register that feeds the master side. A new word can be taken every
// cycle unless the master side stalls. The rate is set by the state loop: the
// next tick needs this tick's error, sum and duty; all three multipliers sit
// in that loop. The output register lets the slave side keep accepting while a
// finished result waits; when the result register is full and stalled, the
// input register holds one more word and then tready drops. Gains are Q8.8
// unsigned, duty is Q16 percent clamped to +/-100; with zero duty both drive
// lines are high. Gains should only be written while no tick is in flight.

module motor_speed_pid_duty #(
    parameter int SUM_WIDTH = 24
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_write,
    input  wire logic [mspd_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [mspd_pkg::GAIN_W-1:0]  cfg_data,
    // slave side
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [31:0]                  s_tdata,  // desired_speed, measured_speed
    // master side
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [39:0]                       m_tdata   // duty_magnitude, drive_a,
                                                        // drive_b, duty_fixed
);

    localparam logic signed [mspd_pkg::DUTY_W-1:0] ACC_HI =
        mspd_pkg::DUTY_W'(mspd_pkg::DUTY_MAX);
    localparam logic signed [mspd_pkg::DUTY_W-1:0] ACC_LO =
        -mspd_pkg::DUTY_W'(mspd_pkg::DUTY_MAX);

    mspd_pkg::gains_t gains;

    // input register
    logic                                  in_valid_reg;
    logic                                  in_valid_next;
    logic signed [mspd_pkg::SPEED_W-1:0]   desired_reg;
    logic signed [mspd_pkg::SPEED_W-1:0]   measured_reg;

    // controller state
    logic signed [mspd_pkg::ERR_W-1:0]     last_error_reg;
    logic signed [mspd_pkg::ERR_W-1:0]     last_error_next;
    logic signed [SUM_WIDTH-1:0]           error_sum_reg;
    logic signed [SUM_WIDTH-1:0]           error_sum_next;
    logic signed [mspd_pkg::DUTY_W-1:0]    duty_acc_reg;
    logic signed [mspd_pkg::DUTY_W-1:0]    duty_acc_next;

    // result register
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    mspd_pkg::result_t                     result_reg;
    mspd_pkg::result_t                     result_next;

    logic                                  accept;
    logic                                  advance;

    mspd_gains u_gains
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gains     (gains)
    );

    mspd_law #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_law
    (
        .desired_speed   (desired_reg),
        .measured_speed  (measured_reg),
        .gains           (gains),
        .last_error      (last_error_reg),
        .error_sum       (error_sum_reg),
        .duty_acc        (duty_acc_reg),
        .last_error_next (last_error_next),
        .error_sum_next  (error_sum_next),
        .duty_acc_next   (duty_acc_next),
        .result_next     (result_next)
    );

    // word moves from input to result register when the latter is free or drains
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || m_tready);
        s_tready       = !in_valid_reg || advance;
        accept         = s_tvalid && s_tready;
        in_valid_next  = accept || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            duty_acc_reg   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                last_error_reg <= last_error_next;
                error_sum_reg  <= error_sum_next;
                duty_acc_reg   <= duty_acc_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desired_reg  <= s_tdata[14:0];
            measured_reg <= s_tdata[29:15];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, result_reg};

    `MSPD_ASSERT_NOW(a_acc_range, clk, rst_n, 1'b1, (duty_acc_reg <= ACC_HI) && (duty_acc_reg >= ACC_LO), "duty accumulator out of range")
    `MSPD_ASSERT_NOW(a_drive_line, clk, rst_n, out_valid_reg, result_reg.drive_a || result_reg.drive_b, "no drive line set")
    `MSPD_ASSERT_NOW(a_mag_range, clk, rst_n, out_valid_reg, result_reg.duty_magnitude <= 7'(mspd_pkg::MAG_MAX), "duty magnitude above 100")
    `MSPD_ASSERT_NEXT(a_advance_fill, clk, rst_n, advance, out_valid_reg, "advanced word lost")
    `MSPD_ASSERT_NOW(a_full_stall, clk, rst_n, in_valid_reg && out_valid_reg && !m_tready, !s_tready, "accepting while both stages full")

endmodule

`default_nettype wire

FILE: src/mspd_gains.sv
// Gain register bank written through the plain configuration port.
// Depends on mspd_pkg.
`default_nettype none

module mspd_gains
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [mspd_pkg::INDEX_W-1:0]     cfg_index,
    input  wire logic [mspd_pkg::GAIN_W-1:0]      cfg_data,
    output mspd_pkg::gains_t                      gains
);

    mspd_pkg::gains_t gains_reg;
    mspd_pkg::gains_t gains_next;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                mspd_pkg::REG_GAIN_P: gains_next.kp = cfg_data;
                mspd_pkg::REG_GAIN_I: gains_next.ki = cfg_data;
                mspd_pkg::REG_GAIN_D: gains_next.kd = cfg_data;
                default:              gains_next = gains_reg;  // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

`default_nettype wire

FILE: src/mspd_law.sv
// One control tick of the PID law: error, saturating sum, three products,
// duty update, minimum duty, clamp and output formatting. Pure logic.
// Depends on mspd_pkg.
`default_nettype none

module mspd_law #(
    parameter int SUM_WIDTH = 24
)
(
    input  wire logic signed [mspd_pkg::SPEED_W-1:0] desired_speed,
    input  wire logic signed [mspd_pkg::SPEED_W-1:0] measured_speed,
    input  wire mspd_pkg::gains_t                    gains,
    input  wire logic signed [mspd_pkg::ERR_W-1:0]   last_error,
    input  wire logic signed [SUM_WIDTH-1:0]         error_sum,
    input  wire logic signed [mspd_pkg::DUTY_W-1:0]  duty_acc,
    output logic signed [mspd_pkg::ERR_W-1:0]        last_error_next,
    output logic signed [SUM_WIDTH-1:0]              error_sum_next,
    output logic signed [mspd_pkg::DUTY_W-1:0]       duty_acc_next,
    output mspd_pkg::result_t                        result_next
);

    // widest product is ki*sum (SUM_WIDTH+17) or kd*diff (34); two guard bits
    localparam int PROD_W = (SUM_WIDTH + 17 > 34) ? SUM_WIDTH + 17 : 34;
    localparam int TOT_W  = PROD_W + 2;
    localparam int STEP_W = 19;
    localparam int WIDE_W = 28;

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [TOT_W-1:0]  STEP_HI  = TOT_W'(mspd_pkg::STEP_LIMIT);
    localparam logic signed [TOT_W-1:0]  STEP_LO  = -TOT_W'(mspd_pkg::STEP_LIMIT);
    localparam logic signed [WIDE_W-1:0] ONE_HI   = WIDE_W'(mspd_pkg::DUTY_ONE);
    localparam logic signed [WIDE_W-1:0] ONE_LO   = -WIDE_W'(mspd_pkg::DUTY_ONE);
    localparam logic signed [WIDE_W-1:0] MAX_HI   = WIDE_W'(mspd_pkg::DUTY_MAX);
    localparam logic signed [WIDE_W-1:0] MAX_LO   = -WIDE_W'(mspd_pkg::DUTY_MAX);

    logic signed [mspd_pkg::ERR_W-1:0]  err;
    logic signed [SUM_WIDTH:0]          sum_wide;
    logic signed [SUM_WIDTH-1:0]        sum_sat;
    logic signed [mspd_pkg::ERR_W:0]    diff;
    logic signed [mspd_pkg::GAIN_W:0]   kp_s;
    logic signed [mspd_pkg::GAIN_W:0]   ki_s;
    logic signed [mspd_pkg::GAIN_W:0]   kd_s;
    logic signed [32:0]                 p_kp;
    logic signed [33:0]                 p_kd;
    logic signed [SUM_WIDTH+16:0]       p_ki;
    logic signed [TOT_W-1:0]            total;
    logic signed [STEP_W-1:0]           step;
    logic signed [STEP_W+7:0]           step_q16;
    logic signed [WIDE_W-1:0]           duty_sum;
    logic signed [WIDE_W-1:0]           duty_min;
    logic signed [WIDE_W-1:0]           duty_clamp;
    logic signed [mspd_pkg::DUTY_W-1:0] duty;
    logic [mspd_pkg::DUTY_W-1:0]        duty_abs;
    logic                               want_fwd;
    logic                               want_rev;
    logic                               flip;

    always_comb
    begin
        err = mspd_pkg::ERR_W'(desired_speed) - mspd_pkg::ERR_W'(measured_speed);

        // saturating running sum
        sum_wide = (SUM_WIDTH+1)'(error_sum) + (SUM_WIDTH+1)'(err);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1])
            sum_sat = sum_wide[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_wide[SUM_WIDTH-1:0];

        diff = (mspd_pkg::ERR_W+1)'(err) - (mspd_pkg::ERR_W+1)'(last_error);

        kp_s = {1'b0, gains.kp};
        ki_s = {1'b0, gains.ki};
        kd_s = {1'b0, gains.kd};
        p_kp = kp_s * err;
        p_kd = kd_s * diff;
        p_ki = ki_s * sum_sat;

        total = TOT_W'(p_kp) + TOT_W'(p_kd) + TOT_W'(p_ki);

        // a step past the limit saturates the duty in any case
        if (total > STEP_HI)
            step = STEP_W'(STEP_HI);
        else if (total < STEP_LO)
            step = STEP_W'(STEP_LO);
        else
            step = total[STEP_W-1:0];

        step_q16 = {step, 8'h00};
        duty_sum = WIDE_W'(duty_acc) + WIDE_W'(step_q16);

        // minimum one percent in the wanted direction
        want_fwd = !desired_speed[mspd_pkg::SPEED_W-1] && (desired_speed != '0);
        want_rev = desired_speed[mspd_pkg::SPEED_W-1];
        if (want_fwd && (duty_sum < ONE_HI))
            duty_min = ONE_HI;
        else if (want_rev && (duty_sum > ONE_LO))
            duty_min = ONE_LO;
        else
            duty_min = duty_sum;

        if (duty_min > MAX_HI)
            duty_clamp = MAX_HI;
        else if (duty_min < MAX_LO)
            duty_clamp = MAX_LO;
        else
            duty_clamp = duty_min;

        duty = duty_clamp[mspd_pkg::DUTY_W-1:0];

        // sign change of the error clears the sum after it has been used
        flip = err[mspd_pkg::ERR_W-1] ^ last_error[mspd_pkg::ERR_W-1];

        last_error_next = err;
        error_sum_next  = flip ? '0 : sum_sat;
        duty_acc_next   = duty;

        duty_abs = duty[mspd_pkg::DUTY_W-1] ? -duty : duty;
        result_next.duty_magnitude = duty_abs[16 +: mspd_pkg::MAG_W];
        result_next.drive_a        = !duty[mspd_pkg::DUTY_W-1];
        result_next.drive_b        = duty[mspd_pkg::DUTY_W-1] || (duty == '0);
        result_next.duty_fixed     = duty;
    end

endmodule

`default_nettype wire

FILE: dv/tb_motor_speed_pid_duty.sv
// Self-checking testbench for motor_speed_pid_duty: PID ticks in, clamped duty words out.
// Depends on mspd_pkg and the RTL under src; a built-in predictor models the control law.
// Runs directed corner cases, then long saturating runs and random gain/speed mixes.

module tb_motor_speed_pid_duty;

    localparam int SUM_W = 24;
    // index 3 has no register behind it; writes there must be dropped
    localparam logic [mspd_pkg::INDEX_W-1:0] REG_SPARE = 2'd3;
    // Q8 step saturation ahead of the duty update
    localparam longint STEP_CLAMP = longint'(1) << 40;
    localparam int CYCLE_LIMIT = 200000;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_write = 1'b0;
    logic [mspd_pkg::INDEX_W-1:0] cfg_index = '0;
    logic [mspd_pkg::GAIN_W-1:0]  cfg_data  = '0;
    logic                         s_tvalid  = 1'b0;
    logic                         s_tready;
    logic [31:0]                  s_tdata   = '0;   // desired_speed, measured_speed
    logic                         m_tvalid;
    logic                         m_tready  = 1'b0;
    logic [39:0]                  m_tdata;  // duty_magnitude, drive_a, drive_b, duty_fixed

    // gains as last written
    logic [mspd_pkg::GAIN_W-1:0] gain_p = '0;
    logic [mspd_pkg::GAIN_W-1:0] gain_i = '0;
    logic [mspd_pkg::GAIN_W-1:0] gain_d = '0;

    // controller state mirror
    logic signed [mspd_pkg::ERR_W-1:0]  last_err = '0;
    logic signed [SUM_W-1:0]            err_sum  = '0;
    logic signed [mspd_pkg::DUTY_W-1:0] duty_acc = '0;

    mspd_pkg::result_t pending_duty_q[$];
    mspd_pkg::result_t seen_duty;
    mspd_pkg::result_t want_duty;

    int idle_pct      = 22;
    int cycle_count   = 0;
    int ticks_sent    = 0;
    int words_checked = 0;
    int mismatches    = 0;
    int sum_sat_ticks = 0;
    int flip_ticks    = 0;

    motor_speed_pid_duty #(
        .SUM_WIDTH (SUM_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard: a hung handshake or a lost word ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d words outstanding",
                     $time, CYCLE_LIMIT, pending_duty_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Master-side back-pressure, same idle rate as the sender.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    // One control tick of the PID law; updates the state mirror and returns the word
    // the block should emit for it.
    function automatic mspd_pkg::result_t pid_tick(
        input logic signed [mspd_pkg::SPEED_W-1:0] desired,
        input logic signed [mspd_pkg::SPEED_W-1:0] measured);
        longint            des_l, meas_l, err_l, last_l, sum_l, sum_hi, sum_lo;
        longint            kp_l, ki_l, kd_l, step_l, duty_l, mag_l;
        mspd_pkg::result_t r;
        des_l  = desired;
        meas_l = measured;
        last_l = last_err;
        sum_l  = err_sum;
        kp_l   = gain_p;
        ki_l   = gain_i;
        kd_l   = gain_d;
        err_l  = des_l - meas_l;

        // saturating error sum
        sum_hi = (longint'(1) << (SUM_W - 1)) - 1;
        sum_lo = -sum_hi - 1;
        sum_l  = sum_l + err_l;
        if (sum_l > sum_hi)
        begin
            sum_l = sum_hi;
            sum_sat_ticks++;
        end
        else if (sum_l < sum_lo)
        begin
            sum_l = sum_lo;
            sum_sat_ticks++;
        end

        // Q8 step, saturated, then scaled to Q16 and added to the accumulator
        step_l = kp_l * err_l + kd_l * (err_l - last_l) + ki_l * sum_l;
        if (step_l > STEP_CLAMP)
            step_l = STEP_CLAMP;
        else if (step_l < -STEP_CLAMP)
            step_l = -STEP_CLAMP;
        duty_l = longint'(duty_acc) + step_l * 256;

        // sign change of the error wipes the sum, after this tick's ki term
        if (err_l[15] != last_err[15])
        begin
            sum_l = 0;
            flip_ticks++;
        end
        err_sum  = sum_l[SUM_W-1:0];
        last_err = err_l[mspd_pkg::ERR_W-1:0];

        // minimum one percent towards the wanted direction
        if (des_l > 0 && duty_l < mspd_pkg::DUTY_ONE)
            duty_l = mspd_pkg::DUTY_ONE;
        else if (des_l < 0 && duty_l > -mspd_pkg::DUTY_ONE)
            duty_l = -mspd_pkg::DUTY_ONE;

        if (duty_l > mspd_pkg::DUTY_MAX)
            duty_l = mspd_pkg::DUTY_MAX;
        else if (duty_l < -mspd_pkg::DUTY_MAX)
            duty_l = -mspd_pkg::DUTY_MAX;
        duty_acc = duty_l[mspd_pkg::DUTY_W-1:0];

        mag_l = (duty_l < 0) ? -duty_l : duty_l;
        mag_l = mag_l >> 16;
        r.duty_magnitude = mag_l[mspd_pkg::MAG_W-1:0];
        r.drive_a        = (duty_l >= 0);
        r.drive_b        = (duty_l <= 0);
        r.duty_fixed     = duty_l[mspd_pkg::DUTY_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Result checker: every accepted word against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_duty = mspd_pkg::result_t'(m_tdata[32:0]);
            if (pending_duty_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, got %h",
                         $time, m_tdata);
            end
            else
            begin
                want_duty = pending_duty_q.pop_front();
                check_field("duty_magnitude", want_duty.duty_magnitude,
                            seen_duty.duty_magnitude);
                check_field("drive_a", want_duty.drive_a, seen_duty.drive_a);
                check_field("drive_b", want_duty.drive_b, seen_duty.drive_b);
                check_field("duty_fixed", $signed(want_duty.duty_fixed),
                            $signed(seen_duty.duty_fixed));
                words_checked++;
            end
        end
    end

    // Offer one tick word, with a random gap first, and predict it once taken.
    // tvalid stays high from one word to the next when there is no gap.
    task automatic send_tick(input logic signed [mspd_pkg::SPEED_W-1:0] desired,
                             input logic signed [mspd_pkg::SPEED_W-1:0] measured);
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, measured, desired};
        do
            @(posedge clk);
        while (!s_tready);
        pending_duty_q.push_back(pid_tick(desired, measured));
        ticks_sent++;
    endtask

    // Stop sending and let every outstanding word come back, plus a short margin.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_duty_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // All three gains back to back, then a write to the spare index which must
    // leave them untouched. Only called with the block idle.
    task automatic write_gains(input logic [mspd_pkg::GAIN_W-1:0] kp,
                               input logic [mspd_pkg::GAIN_W-1:0] ki,
                               input logic [mspd_pkg::GAIN_W-1:0] kd);
        cfg_write <= 1'b1;
        cfg_index <= mspd_pkg::REG_GAIN_P;
        cfg_data  <= kp;
        @(posedge clk);
        cfg_index <= mspd_pkg::REG_GAIN_I;
        cfg_data  <= ki;
        @(posedge clk);
        cfg_index <= mspd_pkg::REG_GAIN_D;
        cfg_data  <= kd;
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= mspd_pkg::GAIN_W'($urandom);
        @(posedge clk);
        cfg_write <= 1'b0;
        gain_p = kp;
        gain_i = ki;
        gain_d = kd;
    endtask

    // Gains still at reset (all zero): only the minimum-duty rule moves the duty.
    // Ends with the accumulator at minus one percent.
    task automatic test_reset_gains();
        send_tick(0, 0);        // zero duty, both drive lines high
        send_tick(100, 0);      // forced +1 %
        send_tick(-100, 0);     // forced -1 %
        send_tick(0, 0);        // zero demand: no forcing, duty holds
    endtask

    // Tiny kp from -1 %: exact zero, then duty below one percent either way.
    task automatic test_fractional_duty();
        wait_idle();
        write_gains(16'd1, 16'd0, 16'd0);
        send_tick(0, -256);     // step of exactly +1 % lands on zero
        send_tick(0, -100);     // small positive duty, magnitude 0, drive_a only
        send_tick(0, 200);      // small negative duty, drive_b only
    endtask

    // Field extremes with every gain bit set, then a derivative-only setting.
    task automatic test_field_extremes();
        wait_idle();
        write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick(16383, -16384);   // largest positive error: huge step, +100 %
        send_tick(-16384, 16383);   // largest negative error, sign change
        send_tick(16383, 16383);
        send_tick(-16384, -16384);
        send_tick(0, 16383);
        wait_idle();
        write_gains(16'd0, 16'd0, 16'h8000);
        send_tick(-1, 0);
        send_tick(16383, 0);
        send_tick(0, -16384);
        send_tick(-16384, 0);
    endtask

    // Long same-sign runs drive the error sum into both saturation limits; only ki
    // is set so a wrapped sum would pull the duty the wrong way. The positive run
    // has no idling on either side.
    task automatic test_sum_saturation();
        wait_idle();
        write_gains(16'd0, 16'd1, 16'd0);
        idle_pct = 0;
        repeat (290)
            send_tick(mspd_pkg::SPEED_W'($urandom_range(15000, 16383)),
                      mspd_pkg::SPEED_W'(-int'($urandom_range(15000, 16384))));
        idle_pct = 22;
        repeat (290)
            send_tick(mspd_pkg::SPEED_W'(-int'($urandom_range(15000, 16384))),
                      mspd_pkg::SPEED_W'($urandom_range(15000, 16383)));
    endtask

    // Random gains per phase, mostly small so the duty leaves the clamps; speeds
    // mostly near the set point with some full-range noise and some zero demand.
    task automatic test_random_mix();
        int desired_i;
        int measured_i;
        repeat (4)
        begin
            wait_idle();
            write_gains(($urandom_range(3) == 0) ? mspd_pkg::GAIN_W'($urandom)
                                                 : mspd_pkg::GAIN_W'($urandom_range(48)),
                        ($urandom_range(3) == 0) ? mspd_pkg::GAIN_W'($urandom)
                                                 : mspd_pkg::GAIN_W'($urandom_range(4)),
                        ($urandom_range(3) == 0) ? mspd_pkg::GAIN_W'($urandom)
                                                 : mspd_pkg::GAIN_W'($urandom_range(48)));
            repeat (80)
            begin
                desired_i = ($urandom_range(7) == 0) ? 0 : int'($urandom_range(32767)) - 16384;
                if ($urandom_range(9) < 7)
                    measured_i = desired_i + int'($urandom_range(64)) - 32;
                else
                    measured_i = int'($urandom_range(32767)) - 16384;
                if (measured_i > 16383)
                    measured_i = 16383;
                else if (measured_i < -16384)
                    measured_i = -16384;
                send_tick(mspd_pkg::SPEED_W'(desired_i), mspd_pkg::SPEED_W'(measured_i));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_gains();
        test_fractional_duty();
        test_field_extremes();
        test_sum_saturation();
        test_random_mix();

        wait_idle();
        repeat (8) @(posedge clk);

        $display("%0d ticks sent, %0d duty words checked, %0d mismatches",
                 ticks_sent, words_checked, mismatches);
        $display("error sum saturated on %0d ticks, cleared by sign change on %0d",
                 sum_sat_ticks, flip_ticks);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
